@@ rtl/bbc_pkg.sv @@
// bbc_pkg: shared types, character constants and helper functions of the
// bracket balance checker. No dependencies; used by every rtl file but bbc_ram.
`default_nettype none

package bbc_pkg;

    // characters of interest
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    // width of reported positions
    localparam int RPT_POS_W = 16;

    // bracket pair codes
    localparam logic [1:0] CODE_PAREN   = 2'd0;
    localparam logic [1:0] CODE_BRACE   = 2'd1;
    localparam logic [1:0] CODE_BRACKET = 2'd2;

    // what the front part makes of one byte
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    // report kinds
    typedef enum logic [2:0] {
        KIND_UNMATCHED = 3'd0,
        KIND_MISMATCH  = 3'd1,
        KIND_UNCLOSED  = 3'd2,
        KIND_OVERFLOW  = 3'd3,
        KIND_SUMMARY   = 3'd4
    } t_kind;

    // classified byte passed from front to back
    typedef struct packed {
        t_op                  op;
        logic [1:0]           code;
        logic [7:0]           char_val;
        logic                 eot;
        logic [RPT_POS_W-1:0] line;
        logic [RPT_POS_W-1:0] col;
    } t_item;

    // one stack entry
    typedef struct packed {
        logic [1:0]           code;
        logic [RPT_POS_W-1:0] line;
        logic [RPT_POS_W-1:0] col;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one report
    typedef struct packed {
        t_kind                kind;
        logic [7:0]           expected_char;
        logic [7:0]           found_char;
        logic [RPT_POS_W-1:0] line_number;
        logic [RPT_POS_W-1:0] column_number;
        logic                 balanced;
        logic                 last;
    } t_result;

    // code 3 is never stored; it folds onto the paren pair
    function automatic logic [1:0] code_norm(input logic [1:0] code);
        logic [1:0] r;
        case (code)
            CODE_BRACE:   r = CODE_BRACE;
            CODE_BRACKET: r = CODE_BRACKET;
            default:      r = CODE_PAREN;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] open_char(input logic [1:0] code);
        logic [7:0] r;
        case (code)
            CODE_BRACE:   r = CH_LBRACE;
            CODE_BRACKET: r = CH_LBRACKET;
            default:      r = CH_LPAREN;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] close_char(input logic [1:0] code);
        logic [7:0] r;
        case (code)
            CODE_BRACE:   r = CH_RBRACE;
            CODE_BRACKET: r = CH_RBRACKET;
            default:      r = CH_RPAREN;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bbc_ram.sv @@
// bbc_ram: generic single-write, single-read memory with registered read.
// No dependencies.
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_front.sv @@
// bbc_front: accepts text bytes, keeps line and column, classifies brackets.
// Depends on bbc_pkg.
`default_nettype none

module bbc_front #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_eot,
    output logic                o_ready,
    output logic                o_push,
    output bbc_pkg::t_item      o_item,
    input  wire logic           i_q_ready
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    logic [POSITION_WIDTH-1:0] r_line, n_line;
    logic [POSITION_WIDTH-1:0] r_col,  n_col;
    logic [POSITION_WIDTH-1:0] pos_line, pos_col;
    bbc_pkg::t_op              op;
    logic [1:0]                code;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    // byte classification
    always_comb begin
        op   = bbc_pkg::OP_NONE;
        code = bbc_pkg::CODE_PAREN;
        case (i_char)
            bbc_pkg::CH_LPAREN: begin
                op = bbc_pkg::OP_OPEN;  code = bbc_pkg::CODE_PAREN;
            end
            bbc_pkg::CH_LBRACE: begin
                op = bbc_pkg::OP_OPEN;  code = bbc_pkg::CODE_BRACE;
            end
            bbc_pkg::CH_LBRACKET: begin
                op = bbc_pkg::OP_OPEN;  code = bbc_pkg::CODE_BRACKET;
            end
            bbc_pkg::CH_RPAREN: begin
                op = bbc_pkg::OP_CLOSE; code = bbc_pkg::CODE_PAREN;
            end
            bbc_pkg::CH_RBRACE: begin
                op = bbc_pkg::OP_CLOSE; code = bbc_pkg::CODE_BRACE;
            end
            bbc_pkg::CH_RBRACKET: begin
                op = bbc_pkg::OP_CLOSE; code = bbc_pkg::CODE_BRACKET;
            end
            default: begin
                op   = bbc_pkg::OP_NONE;
                code = bbc_pkg::CODE_PAREN;
            end
        endcase
    end

    // saturating position update for this byte
    always_comb begin
        pos_col  = (r_col != POS_MAX) ? r_col + POSITION_WIDTH'(1) : r_col;
        pos_line = r_line;
        if (i_char == bbc_pkg::CH_NEWLINE) begin
            pos_line = (r_line != POS_MAX) ? r_line + POSITION_WIDTH'(1) : r_line;
            pos_col  = '0;
        end
    end

    // counters restart after the final byte of a text
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (o_push) begin
            if (i_eot) begin
                n_line = POSITION_WIDTH'(1);
                n_col  = '0;
            end else begin
                n_line = pos_line;
                n_col  = pos_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= POSITION_WIDTH'(1);
            r_col  <= '0;
        end else begin
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    // classified item toward the queue
    always_comb begin
        o_item.op       = op;
        o_item.code     = code;
        o_item.char_val = i_char;
        o_item.eot      = i_eot;
        o_item.line     = bbc_pkg::RPT_POS_W'(pos_line);
        o_item.col      = bbc_pkg::RPT_POS_W'(pos_col);
    end

endmodule

`default_nettype wire

@@ rtl/bbc_queue.sv @@
// bbc_queue: two-entry queue of classified items between front and back.
// Depends on bbc_pkg.
`default_nettype none

module bbc_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  bbc_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output bbc_pkg::t_item o_item,
    input  wire logic      i_pop
);

    logic [1:0]     r_cnt, n_cnt;
    logic           r_wptr, r_rptr;
    bbc_pkg::t_item r_mem [2];
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bbc_back.sv @@
// bbc_back: bracket stack, error reports, drain and summary, output register.
// Depends on bbc_pkg and bbc_ram.
`default_nettype none

module bbc_back #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_item_valid,
    input  bbc_pkg::t_item   i_item,
    output logic             o_item_ready,
    output logic             o_res_valid,
    output bbc_pkg::t_result o_res,
    input  wire logic        i_res_ready
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CMP       = 5'b00010,
        S_DRAIN_RD  = 5'b00100,
        S_DRAIN_OUT = 5'b01000,
        S_SUM       = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_err, n_err;
    logic          r_eot, n_eot;
    logic [1:0]    r_code, n_code;
    logic [7:0]    r_char, n_char;
    logic [bbc_pkg::RPT_POS_W-1:0] r_line, n_line;
    logic [bbc_pkg::RPT_POS_W-1:0] r_col,  n_col;
    logic             r_ovalid, n_ovalid;
    bbc_pkg::t_result r_res, n_res;

    logic                    res_free;
    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    bbc_pkg::t_entry         ram_wdata, top;
    logic [bbc_pkg::ENTRY_W-1:0] ram_rdata;

    bbc_ram #(
        .WIDTH (bbc_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign top       = bbc_pkg::t_entry'(ram_rdata);
    assign res_free  = !r_ovalid || i_res_ready;
    assign ram_waddr = r_count[AW-1:0];
    assign ram_raddr = AW'(r_count - CW'(1));
    assign ram_wdata = '{code: i_item.code, line: i_item.line, col: i_item.col};

    // stack control and report generation
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_eot        = r_eot;
        n_code       = r_code;
        n_char       = r_char;
        n_line       = r_line;
        n_col        = r_col;
        n_ovalid     = r_ovalid && !i_res_ready;
        n_res        = r_res;
        o_item_ready = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = res_free;
                if (i_item_valid && res_free) begin
                    n_eot   = i_item.eot;
                    n_code  = i_item.code;
                    n_char  = i_item.char_val;
                    n_line  = i_item.line;
                    n_col   = i_item.col;
                    n_state = i_item.eot ? S_DRAIN_RD : S_IDLE;
                    case (i_item.op)
                        bbc_pkg::OP_OPEN: begin
                            if (r_count == FULL) begin
                                n_ovalid            = 1'b1;
                                n_res               = '0;
                                n_res.kind          = bbc_pkg::KIND_OVERFLOW;
                                n_res.found_char    = i_item.char_val;
                                n_res.line_number   = i_item.line;
                                n_res.column_number = i_item.col;
                                n_res.last          = !i_item.eot;
                                n_err               = 1'b1;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        bbc_pkg::OP_CLOSE: begin
                            if (r_count == '0) begin
                                n_ovalid            = 1'b1;
                                n_res               = '0;
                                n_res.kind          = bbc_pkg::KIND_UNMATCHED;
                                n_res.found_char    = i_item.char_val;
                                n_res.line_number   = i_item.line;
                                n_res.column_number = i_item.col;
                                n_res.last          = !i_item.eot;
                                n_err               = 1'b1;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_CMP;
                            end
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (res_free) begin
                    n_count = r_count - CW'(1);
                    n_state = r_eot ? S_DRAIN_RD : S_IDLE;
                    if (bbc_pkg::code_norm(top.code) != r_code) begin
                        n_ovalid            = 1'b1;
                        n_res               = '0;
                        n_res.kind          = bbc_pkg::KIND_MISMATCH;
                        n_res.expected_char = bbc_pkg::close_char(top.code);
                        n_res.found_char    = r_char;
                        n_res.line_number   = r_line;
                        n_res.column_number = r_col;
                        n_res.last          = !r_eot;
                        n_err               = 1'b1;
                    end
                end
            end
            S_DRAIN_RD: begin
                if (r_count == '0) begin
                    n_state = S_SUM;
                end else begin
                    ram_re  = 1'b1;
                    n_count = r_count - CW'(1);
                    n_state = S_DRAIN_OUT;
                end
            end
            S_DRAIN_OUT: begin
                if (res_free) begin
                    n_ovalid            = 1'b1;
                    n_res               = '0;
                    n_res.kind          = bbc_pkg::KIND_UNCLOSED;
                    n_res.found_char    = bbc_pkg::open_char(top.code);
                    n_res.line_number   = top.line;
                    n_res.column_number = top.col;
                    n_err               = 1'b1;
                    n_state             = S_DRAIN_RD;
                end
            end
            S_SUM: begin
                if (res_free) begin
                    n_ovalid            = 1'b1;
                    n_res               = '0;
                    n_res.kind          = bbc_pkg::KIND_SUMMARY;
                    n_res.line_number   = r_line;
                    n_res.column_number = r_col;
                    n_res.balanced      = !r_err;
                    n_res.last          = 1'b1;
                    n_err               = 1'b0;
                    n_count             = '0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_eot  <= n_eot;
        r_code <= n_code;
        r_char <= n_char;
        r_line <= n_line;
        r_col  <= n_col;
        r_res  <= n_res;
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
// Bracket balance checker. A front part tracks line and column of each text byte and
// classifies brackets; a two-entry queue feeds a back part that keeps a stack of open
// brackets in a STACK_DEPTH x 34 memory with registered read and issues error reports.
// A plain byte, a newline or an opening bracket is handled in the idle state of the
// back part; a closing bracket on a non-empty stack also passes a compare state,
// because the top entry comes from the memory read port. At end of text the back
// part drains the stack, reading and then reporting each unclosed bracket, then
// finds the stack empty and issues the summary beat. Each output beat waits in an
// output register, so the front keeps taking bytes while the queue has room.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back and bbc_ram.
`default_nettype none

module bracket_balance_checker #(
    parameter int STACK_DEPTH    = 32,
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] character
    input  wire logic        s_axis_tlast,  // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] expected_char, [15:8] found_char, [31:16] line_number,
    // [47:32] column_number, [48] balanced, [55:49] zero
    output logic [55:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser,  // [2:0] kind
    output logic             m_axis_tlast   // last
);

    logic             f_push, q_ready, q_valid, q_pop;
    bbc_pkg::t_item   f_item, q_item;
    bbc_pkg::t_result res;

    bbc_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_char    (s_axis_tdata),
        .i_eot     (s_axis_tlast),
        .o_ready   (s_axis_tready),
        .o_push    (f_push),
        .o_item    (f_item),
        .i_q_ready (q_ready)
    );

    bbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_ready (q_pop),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (res),
        .i_res_ready  (m_axis_tready)
    );

    // pack the report beat
    assign m_axis_tdata = {7'd0, res.balanced, res.column_number, res.line_number,
                           res.found_char, res.expected_char};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

@@ rtl/bbc_checker.sv @@
// bbc_checker: port-level assertions for the bracket balance checker, bound to its top.
// Depends on bbc_pkg and bracket_balance_checker.
`default_nettype none

module bbc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled text beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
        else $error("text beat changed while stalled");

    // a stalled report beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("report beat changed while stalled");

    // a summary always closes the reports of its byte
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == bbc_pkg::KIND_SUMMARY |-> m_axis_tlast)
        else $error("summary beat without tlast");

    // balanced flag only in a summary
    a_bal_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bbc_pkg::KIND_SUMMARY |-> !m_axis_tdata[48])
        else $error("balanced set outside summary");

    // expected character only in a mismatch report
    a_exp_mis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bbc_pkg::KIND_MISMATCH |->
            m_axis_tdata[7:0] == 8'd0)
        else $error("expected character outside mismatch report");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

`default_nettype wire

@@ tb/tb_bracket_balance_checker.sv @@
// Self-checking testbench of bracket_balance_checker: random and directed texts are streamed
// in, and every report beat is checked against an in-bench prediction of the bracket stack.
// Depends on bbc_pkg and the rtl of bracket_balance_checker.
`timescale 1ns / 1ps

module tb_bracket_balance_checker;

    localparam int DEPTH       = 32;
    localparam int POS_MAX     = 65535;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 100;

    // bracket characters, indexed by pair code
    localparam logic [23:0] OPEN_SET  = {bbc_pkg::CH_LBRACKET, bbc_pkg::CH_LBRACE,
                                         bbc_pkg::CH_LPAREN};
    localparam logic [23:0] CLOSE_SET = {bbc_pkg::CH_RBRACKET, bbc_pkg::CH_RBRACE,
                                         bbc_pkg::CH_RPAREN};

    typedef struct {
        bbc_pkg::t_kind kind;
        logic [7:0]     expected_char;
        logic [7:0]     found_char;
        logic [15:0]    line_number;
        logic [15:0]    column_number;
        logic           balanced;
        logic           last;
    } t_report;

    typedef struct {
        logic [1:0] code;
        int         line;
        int         col;
    } t_open_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] character
    logic        s_axis_tlast = 1'b0;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] expected_char, [15:8] found_char, [31:16] line_number,
    // [47:32] column_number, [48] balanced, [55:49] zero
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;           // [2:0] kind
    logic        m_axis_tlast;           // last

    // predicted checker state
    t_open_entry open_stack [DEPTH];
    int          open_depth = 0;
    int          cur_line = 1;
    int          cur_col = 0;
    bit          text_has_error = 1'b0;

    t_report     expected_reports [$];
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    bit          rdy_next;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          texts_sent = 0;
    int          beats_checked = 0;
    int          kind_tally [5];
    int          quiet_cycles = 0;

    bracket_balance_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_special(input logic [7:0] c);
        return c == bbc_pkg::CH_LPAREN || c == bbc_pkg::CH_RPAREN ||
               c == bbc_pkg::CH_LBRACE || c == bbc_pkg::CH_RBRACE ||
               c == bbc_pkg::CH_LBRACKET || c == bbc_pkg::CH_RBRACKET ||
               c == bbc_pkg::CH_NEWLINE;
    endfunction

    function automatic void queue_report(input bbc_pkg::t_kind kind, input logic [7:0] exp_c,
                                         input logic [7:0] found_c, input int line,
                                         input int col, input logic bal);
        t_report r;
        r.kind          = kind;
        r.expected_char = exp_c;
        r.found_char    = found_c;
        r.line_number   = line[15:0];
        r.column_number = col[15:0];
        r.balanced      = bal;
        r.last          = 1'b0;
        expected_reports.insert(expected_reports.size(), r);
        kind_tally[kind]++;
    endfunction

    // advance the predicted stack and position by one byte, queue the reports it causes
    function automatic void predict_reports(input logic [7:0] c, input logic eot);
        int         n_before;
        int         open_code;
        int         close_code;
        logic [1:0] top;
        n_before   = expected_reports.size();
        open_code  = -1;
        close_code = -1;
        for (int k = 0; k < 3; k++) begin
            if (c == OPEN_SET[k*8 +: 8]) open_code = k;
            if (c == CLOSE_SET[k*8 +: 8]) close_code = k;
        end
        if (cur_col < POS_MAX) cur_col++;
        if (c == bbc_pkg::CH_NEWLINE) begin
            if (cur_line < POS_MAX) cur_line++;
            cur_col = 0;
        end else if (open_code >= 0) begin
            if (open_depth >= DEPTH) begin
                queue_report(bbc_pkg::KIND_OVERFLOW, 8'h00, c, cur_line, cur_col, 1'b0);
                text_has_error = 1'b1;
            end else begin
                open_stack[open_depth].code = open_code[1:0];
                open_stack[open_depth].line = cur_line;
                open_stack[open_depth].col  = cur_col;
                open_depth++;
            end
        end else if (close_code >= 0) begin
            if (open_depth == 0) begin
                queue_report(bbc_pkg::KIND_UNMATCHED, 8'h00, c, cur_line, cur_col, 1'b0);
                text_has_error = 1'b1;
            end else begin
                top = open_stack[open_depth-1].code;
                if (top != close_code[1:0]) begin
                    queue_report(bbc_pkg::KIND_MISMATCH, CLOSE_SET[top*8 +: 8], c,
                                 cur_line, cur_col, 1'b0);
                    text_has_error = 1'b1;
                end
                open_depth--;
            end
        end
        // end of text: unclosed brackets top down, then the summary
        if (eot) begin
            while (open_depth > 0) begin
                open_depth--;
                queue_report(bbc_pkg::KIND_UNCLOSED, 8'h00,
                             OPEN_SET[open_stack[open_depth].code*8 +: 8],
                             open_stack[open_depth].line, open_stack[open_depth].col, 1'b0);
                text_has_error = 1'b1;
            end
            queue_report(bbc_pkg::KIND_SUMMARY, 8'h00, 8'h00, cur_line, cur_col,
                         !text_has_error);
            cur_line       = 1;
            cur_col        = 0;
            text_has_error = 1'b0;
        end
        if (expected_reports.size() > n_before)
            expected_reports[expected_reports.size()-1].last = 1'b1;
    endfunction

    // one input beat, with an optional idle burst before it
    task automatic send_beat(input logic [7:0] c, input logic eot);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_reports(c, eot);
        bytes_sent++;
        if (eot) texts_sent++;
    endtask

    task automatic send_string(input string s, input bit eot_on_last);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], eot_on_last && i == s.len() - 1);
    endtask

    // hold the sender off until every predicted report has come out
    task automatic wait_reports_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_special(c));
        return c;
    endfunction

    // one text: mostly properly nested brackets, otherwise noise
    task automatic send_random_text(input bit well_formed);
        int         len;
        int         depth;
        int         r;
        logic [7:0] c;
        logic [1:0] code;
        logic [1:0] gen_opens [DEPTH];
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
        depth = 0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (well_formed) begin
                if (r < 3 && depth < DEPTH) begin
                    code = 2'($urandom_range(0, 2));
                    gen_opens[depth] = code;
                    depth++;
                    c = OPEN_SET[code*8 +: 8];
                end else if (r < 6 && depth > 0) begin
                    depth--;
                    c = CLOSE_SET[gen_opens[depth]*8 +: 8];
                end else if (r == 6) begin
                    c = bbc_pkg::CH_NEWLINE;
                end else begin
                    c = filler_byte();
                end
            end else begin
                code = 2'($urandom_range(0, 2));
                if (r < 2) c = OPEN_SET[code*8 +: 8];
                else if (r < 4) c = CLOSE_SET[code*8 +: 8];
                else if (r == 4) c = bbc_pkg::CH_NEWLINE;
                else c = 8'($urandom_range(0, 255));
            end
            send_beat(c, 1'b0);
        end
        while (well_formed && depth > 0) begin
            depth--;
            send_beat(CLOSE_SET[gen_opens[depth]*8 +: 8], 1'b0);
        end
        send_beat(well_formed ? filler_byte() : 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // extreme bytes, every bracket, unmatched, mismatched and unclosed cases
    task automatic test_directed();
        send_beat(8'h00, 1'b1);
        send_string("([{}])", 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(bbc_pkg::CH_RPAREN, 1'b1);
        send_string("(\n]{[)", 1'b1);
        send_string("}(\n", 1'b1);
        send_string("]x[", 1'b1);
    endtask

    // fill the stack, push past it, then drain it at end of text
    task automatic test_overflow();
        for (int i = 0; i < DEPTH; i++)
            send_beat(OPEN_SET[(i % 3)*8 +: 8], 1'b0);
        for (int i = DEPTH - 1; i >= 0; i--)
            send_beat(CLOSE_SET[(i % 3)*8 +: 8], i == 0);
        wait_reports_drained();
        for (int i = 0; i < DEPTH + 10; i++)
            send_beat((i % 5 == 4) ? bbc_pkg::CH_NEWLINE : OPEN_SET[(i % 3)*8 +: 8], 1'b0);
        send_beat(bbc_pkg::CH_LBRACE, 1'b1);
    endtask

    task automatic test_random_texts(input int n_bytes);
        int start;
        bit paused;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < n_bytes) begin
            send_random_text($urandom_range(0, 9) < 7);
            if (!paused && bytes_sent - start > n_bytes / 2) begin
                wait_reports_drained();
                paused = 1'b1;
            end
        end
    endtask

    // receiver: checks each report beat and stalls in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected report beat: kind %0d data %h last %b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                t_report e;
                e = expected_reports.pop_front();
                beats_checked++;
                if (m_axis_tuser != e.kind || m_axis_tdata[7:0] != e.expected_char ||
                    m_axis_tdata[15:8] != e.found_char ||
                    m_axis_tdata[31:16] != e.line_number ||
                    m_axis_tdata[47:32] != e.column_number ||
                    m_axis_tdata[48] != e.balanced || m_axis_tdata[55:49] != 7'd0 ||
                    m_axis_tlast != e.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("report %0d mismatch: exp kind %0d exp_ch %h found %h",
                                 beats_checked, e.kind, e.expected_char, e.found_char);
                        $display("    exp line %0d col %0d bal %b last %b",
                                 e.line_number, e.column_number, e.balanced, e.last);
                        $display("    got kind %0d exp_ch %h found %h",
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
                        $display("    got line %0d col %0d bal %b last %b pad %h",
                                 m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tdata[48],
                                 m_axis_tlast, m_axis_tdata[55:49]);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            rdy_next = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rdy_next   = 1'b0;
        end else begin
            rdy_next = 1'b1;
        end
        m_axis_tready <= rdy_next;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d reports outstanding",
                     quiet_cycles, expected_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        foreach (kind_tally[k]) kind_tally[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_reports_drained();
        test_overflow();
        test_random_texts(300);
        // final stretch runs without idling on either side
        idle_on = 1'b0;
        test_random_texts(60);

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d texts, checked %0d report beats",
                 bytes_sent, texts_sent, beats_checked);
        $display("reports: unmatched %0d mismatched %0d unclosed %0d overflow %0d summary %0d",
                 kind_tally[bbc_pkg::KIND_UNMATCHED], kind_tally[bbc_pkg::KIND_MISMATCH],
                 kind_tally[bbc_pkg::KIND_UNCLOSED], kind_tally[bbc_pkg::KIND_OVERFLOW],
                 kind_tally[bbc_pkg::KIND_SUMMARY]);
        if (fail_count == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
rtl/bbc_checker.sv
tb/tb_bracket_balance_checker.sv
